// ===== rtl/tvgs_pkg.sv =====
package tvgs_pkg;

  localparam int DIM_W     = 6;
  localparam int IDX_W     = 6;
  localparam int FRAC_W    = 10;
  localparam int COMP_W    = 16;
  localparam int ACC_W     = 18;
  localparam int POS_W     = 16;
  localparam int VOX_W     = 5;
  localparam int WORD_W    = 3 * COMP_W;
  localparam int COORD_W   = IDX_W + FRAC_W;
  localparam int CFG_IDX_W = 2;
  localparam int QUEUE_D   = 8;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 6'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD,
    ST_FETCH,
    ST_LERP_GO,
    ST_LERP_TAKE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic [DIM_W-1:0]        scale;
    logic [DIM_W-1:0]        dim;
  } coord_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [FRAC_W-1:0] frac;
  } axis_t;

  typedef struct packed {
    vec_t              a;
    vec_t              b;
    logic [FRAC_W-1:0] frac;
  } lerp_req_t;

  // register value of zero acts as one, above the store size acts as the size
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r, input int maxv);
    logic [DIM_W-1:0] v;
    v = r;
    if (r == '0) begin
      v = DIM_W'(1);
    end else if (int'(r) > maxv) begin
      v = DIM_W'(maxv);
    end
    return v;
  endfunction

  function automatic vec_t word_to_vec(input logic [WORD_W-1:0] w);
    vec_t v;
    v.x = ACC_W'($signed(w[COMP_W-1:0]));
    v.y = ACC_W'($signed(w[2*COMP_W-1:COMP_W]));
    v.z = ACC_W'($signed(w[3*COMP_W-1:2*COMP_W]));
    return v;
  endfunction

  function automatic logic [COMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    logic [COMP_W-1:0] s;
    if ((&v[ACC_W-1:COMP_W-1]) || !(|v[ACC_W-1:COMP_W-1])) begin
      s = v[COMP_W-1:0];
    end else if (v[ACC_W-1]) begin
      s = {1'b1, {(COMP_W-1){1'b0}}};
    end else begin
      s = {1'b0, {(COMP_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

// ===== rtl/trilinear_vector_grid_sampler.sv =====
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   cmd, voxel col/row/slice, write vector, position
// out      output     out_valid/out_stall vel_x, vel_y, vel_z
// cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// a write word never stalls the input
// a sample stalls the input while it goes through the shared coordinate multiplier,
// eight corner reads from the single-port grid memory, seven passes through
// the shared vector lerp unit and the hand-off of the result to the output register
// a full output register holds off the end of the next sample until taken
// synchronous reset clears control and sets the dimension registers to 32; grid contents are undefined until written
module trilinear_vector_grid_sampler #(
  parameter int MAX_COLS   = 32,
  parameter int MAX_ROWS   = 32,
  parameter int MAX_SLICES = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic [tvgs_pkg::VOX_W-1:0]            in_voxel_col,
  input  logic [tvgs_pkg::VOX_W-1:0]            in_voxel_row,
  input  logic [tvgs_pkg::VOX_W-1:0]            in_voxel_slice,
  input  logic signed [tvgs_pkg::COMP_W-1:0]    in_write_vx,
  input  logic signed [tvgs_pkg::COMP_W-1:0]    in_write_vy,
  input  logic signed [tvgs_pkg::COMP_W-1:0]    in_write_vz,
  input  logic signed [tvgs_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [tvgs_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [tvgs_pkg::POS_W-1:0]     in_pos_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tvgs_pkg::COMP_W-1:0]    out_vel_x,
  output logic signed [tvgs_pkg::COMP_W-1:0]    out_vel_y,
  output logic signed [tvgs_pkg::COMP_W-1:0]    out_vel_z,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tvgs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tvgs_pkg::DIM_W-1:0]            cfg_data
);
  import tvgs_pkg::*;

  localparam int DEPTH = MAX_COLS * MAX_ROWS * MAX_SLICES;
  localparam int AW    = $clog2(DEPTH);
  localparam int QI_W  = $clog2(QUEUE_D);
  localparam int QC_W  = QI_W + 1;

  // configuration
  logic [DIM_W-1:0] width_r, height_r, depth_r;
  logic [DIM_W-1:0] w_eff, h_eff, d_eff;

  // control
  state_t          state_r, state_nxt;
  logic [1:0]      ax_r, ax_nxt;
  logic [QC_W-1:0] fcnt_r, fcnt_nxt;
  logic [2:0]      stp_r, stp_nxt;
  logic [QC_W-1:0] qcnt_r, qcnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic in_acc, in_sample, mem_we, mem_re, push_word, lerp_take, out_load;

  // payload
  logic signed [POS_W-1:0] px_r, py_r, pz_r;
  axis_t                   gx_r, gy_r, gz_r;
  vec_t                    q_r [QUEUE_D];
  logic [WORD_W-1:0]       mem [DEPTH];
  logic [WORD_W-1:0]       rd_r;
  logic [AW-1:0]           addr;
  logic [COMP_W-1:0]       vx_r, vy_r, vz_r;

  coord_req_t creq;
  axis_t      caxis;
  lerp_req_t  lreq;
  vec_t       lsum;

  logic [IDX_W-1:0] rc, rr, rs;
  logic             in_range;

  assign w_eff = eff_dim(width_r, MAX_COLS);
  assign h_eff = eff_dim(height_r, MAX_ROWS);
  assign d_eff = eff_dim(depth_r, MAX_SLICES);

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_sample = in_acc && (in_cmd == CMD_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
      depth_r  <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_DEPTH:  depth_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_sample) state_nxt = ST_COORD;
      ST_COORD:     if (ax_r == 2'd3) state_nxt = ST_FETCH;
      ST_FETCH:     if (fcnt_r == QC_W'(QUEUE_D)) state_nxt = ST_LERP_GO;
      ST_LERP_GO:   state_nxt = ST_LERP_TAKE;
      ST_LERP_TAKE: state_nxt = (stp_r == 3'd6) ? ST_DONE : ST_LERP_GO;
      ST_DONE:      if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    push_word = 1'b0;
    lerp_take = 1'b0;
    out_load  = 1'b0;
    ax_nxt    = ax_r;
    fcnt_nxt  = fcnt_r;
    stp_nxt   = stp_r;
    case (state_r)
      ST_IDLE: begin
        mem_we   = in_acc && (in_cmd == CMD_WRITE) && in_range;
        ax_nxt   = '0;
        fcnt_nxt = '0;
        stp_nxt  = '0;
      end
      ST_COORD: begin
        ax_nxt = ax_r + 2'd1;
      end
      ST_FETCH: begin
        mem_re    = (fcnt_r < QC_W'(QUEUE_D));
        push_word = (fcnt_r != '0);
        fcnt_nxt  = fcnt_r + QC_W'(1);
      end
      ST_LERP_TAKE: begin
        lerp_take = 1'b1;
        stp_nxt   = stp_r + 3'd1;
      end
      ST_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  always_comb begin
    qcnt_nxt = qcnt_r;
    if (in_sample) begin
      qcnt_nxt = '0;
    end else if (push_word) begin
      qcnt_nxt = qcnt_r + QC_W'(1);
    end else if (lerp_take) begin
      qcnt_nxt = qcnt_r - QC_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ax_r        <= '0;
      fcnt_r      <= '0;
      stp_r       <= '0;
      qcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      fcnt_r      <= fcnt_nxt;
      stp_r       <= stp_nxt;
      qcnt_r      <= qcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // coordinate unit: one axis per cycle, result in the following cycle
  always_comb begin
    case (ax_r)
      2'd0:    creq = '{pos: px_r, scale: w_eff, dim: w_eff};
      2'd1:    creq = '{pos: py_r, scale: w_eff, dim: h_eff};
      default: creq = '{pos: pz_r, scale: d_eff, dim: d_eff};
    endcase
  end

  tvgs_coord u_coord (
    .clk  (clk),
    .req  (creq),
    .axis (caxis)
  );

  always_ff @(posedge clk) begin
    if (in_sample) begin
      px_r <= in_pos_x;
      py_r <= in_pos_y;
      pz_r <= in_pos_z;
    end
    if (state_r == ST_COORD) begin
      if (ax_r == 2'd1) gx_r <= caxis;
      if (ax_r == 2'd2) gy_r <= caxis;
      if (ax_r == 2'd3) gz_r <= caxis;
    end
  end

  // grid memory address: corner bits are {x, y, z} of the fetch count
  always_comb begin
    in_range = (int'(in_voxel_col) < MAX_COLS) && (int'(in_voxel_row) < MAX_ROWS) &&
               (int'(in_voxel_slice) < MAX_SLICES);
    if (state_r == ST_IDLE) begin
      rc = IDX_W'(in_voxel_col);
      rr = IDX_W'(in_voxel_row);
      rs = IDX_W'(in_voxel_slice);
    end else begin
      rc = fcnt_r[2] ? gx_r.hi : gx_r.lo;
      rr = fcnt_r[1] ? gy_r.hi : gy_r.lo;
      rs = fcnt_r[0] ? gz_r.hi : gz_r.lo;
    end
    addr = AW'((int'(rs) * MAX_ROWS + int'(rr)) * MAX_COLS + int'(rc));
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= {in_write_vz, in_write_vy, in_write_vx};
    end
    if (mem_re) begin
      rd_r <= mem[addr];
    end
  end

  // work queue: each lerp pops the two head words and appends its result,
  // which walks z, then y, then x
  always_comb begin
    lreq.a = q_r[0];
    lreq.b = q_r[1];
    if (stp_r < 3'd4) begin
      lreq.frac = gz_r.frac;
    end else if (stp_r < 3'd6) begin
      lreq.frac = gy_r.frac;
    end else begin
      lreq.frac = gx_r.frac;
    end
  end

  tvgs_lerp u_lerp (
    .clk (clk),
    .req (lreq),
    .sum (lsum)
  );

  always_ff @(posedge clk) begin
    if (push_word) begin
      q_r[qcnt_r[QI_W-1:0]] <= word_to_vec(rd_r);
    end else if (lerp_take) begin
      // the result lands right behind the words that remain
      for (int i = 0; i < QUEUE_D - 2; i++) begin
        q_r[i] <= (QC_W'(i + 2) == qcnt_r) ? lsum : q_r[i+2];
      end
      if (qcnt_r == QC_W'(QUEUE_D)) begin
        q_r[QUEUE_D-2] <= lsum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vx_r <= sat16(q_r[0].x);
      vy_r <= sat16(q_r[0].y);
      vz_r <= sat16(q_r[0].z);
    end
  end

  assign out_valid = out_valid_r;
  assign out_vel_x = vx_r;
  assign out_vel_y = vy_r;
  assign out_vel_z = vz_r;

endmodule

// ===== rtl/tvgs_coord.sv =====
module tvgs_coord (
  input  logic               clk,
  input  tvgs_pkg::coord_req_t req,
  output tvgs_pkg::axis_t    axis
);
  import tvgs_pkg::*;

  localparam int PROD_W = POS_W + DIM_W + 1;
  localparam int T_W    = PROD_W + 1;

  logic signed [PROD_W-1:0] prod_r;
  logic [DIM_W-1:0]         dim_r;

  logic signed [T_W-1:0]    t;
  logic [COORD_W-1:0]       c;
  logic [COORD_W-1:0]       lim;
  logic [COORD_W-1:0]       g;
  logic [IDX_W-1:0]         lo;
  logic [IDX_W-1:0]         lo_inc;
  logic [IDX_W-1:0]         top;

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, req.scale}) * req.pos;
    dim_r  <= req.dim;
  end

  always_comb begin
    // offset dim * 8192, then floor to 1/1024 units
    t = T_W'(prod_r) + $signed({{(T_W-DIM_W-13){1'b0}}, dim_r, 13'd0});
    if (t > 0) begin
      c = (|t[T_W-1:COORD_W+4]) ? {COORD_W{1'b1}} : t[COORD_W+3:4];
    end else begin
      c = '0;
    end
    if (dim_r >= DIM_W'(2)) begin
      lim = {IDX_W'(dim_r - DIM_W'(2)), {FRAC_W{1'b0}}};
    end else begin
      lim = '0;
    end
    g      = (c > lim) ? lim : c;
    lo     = g[COORD_W-1:FRAC_W];
    lo_inc = lo + IDX_W'(1);
    top    = IDX_W'(dim_r - DIM_W'(1));
    axis.lo   = lo;
    axis.hi   = (lo_inc > top) ? top : lo_inc;
    axis.frac = g[FRAC_W-1:0];
  end

endmodule

// ===== rtl/tvgs_lerp.sv =====
module tvgs_lerp (
  input  logic                clk,
  input  tvgs_pkg::lerp_req_t req,
  output tvgs_pkg::vec_t      sum
);
  import tvgs_pkg::*;

  localparam int W_W = FRAC_W + 1;
  localparam int P_W = W_W + 1 + ACC_W;

  // floor(w * v / 1024)
  function automatic logic signed [ACC_W-1:0] scaled(input logic [W_W-1:0] w,
                                                    input logic signed [ACC_W-1:0] v);
    logic signed [P_W-1:0] p;
    p = $signed({1'b0, w}) * v;
    return p[ACC_W+FRAC_W-1:FRAC_W];
  endfunction

  logic [W_W-1:0] wa;
  logic [W_W-1:0] wb;
  vec_t           pa_r;
  vec_t           pb_r;

  assign wa = W_W'(1 << FRAC_W) - {1'b0, req.frac};
  assign wb = {1'b0, req.frac};

  always_ff @(posedge clk) begin
    pa_r.x <= scaled(wa, req.a.x);
    pa_r.y <= scaled(wa, req.a.y);
    pa_r.z <= scaled(wa, req.a.z);
    pb_r.x <= scaled(wb, req.b.x);
    pb_r.y <= scaled(wb, req.b.y);
    pb_r.z <= scaled(wb, req.b.z);
  end

  assign sum.x = pa_r.x + pb_r.x;
  assign sum.y = pa_r.y + pb_r.y;
  assign sum.z = pa_r.z + pb_r.z;

endmodule

// ===== rtl/tvgs_checker.sv =====
module tvgs_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               in_cmd,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [tvgs_pkg::COMP_W-1:0] out_vel_x,
  input logic signed [tvgs_pkg::COMP_W-1:0] out_vel_y,
  input logic signed [tvgs_pkg::COMP_W-1:0] out_vel_z,
  input logic                               cfg_ready
);
  import tvgs_pkg::*;

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vel_x) &&
    $stable(out_vel_y) && $stable(out_vel_z))
    else $error("result word changed while stalled");

  // a sample occupies the block
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_cmd == CMD_SAMPLE) |=> in_stall)
    else $error("input not stalled after a sample");

  // a voxel write finishes in its own cycle
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_cmd == CMD_WRITE) |=> !in_stall)
    else $error("input stalled after a voxel write");

  // results appear only at the end of a sample
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a sample in flight");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind trilinear_vector_grid_sampler tvgs_checker u_tvgs_checker (.*);
